// ----- design/utf8d_pkg.sv -----
// Shared types and byte constants for the UTF-8 to UTF-16 decoder.
package utf8d_pkg;

	localparam logic [7:0] BomByte0 = 8'hEF;
	localparam logic [7:0] BomByte1 = 8'hBB;
	localparam logic [7:0] BomByte2 = 8'hBF;

	// Continuation counts held between bytes.
	localparam logic [1:0] RemNone = 2'd0;
	localparam logic [1:0] RemOne  = 2'd1;
	localparam logic [1:0] RemTwo  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        no_character;
		logic        end_of_string;
	} out_item_t;

	typedef struct packed {
		logic      emit;
		out_item_t item;
	} dec_result_t;

endpackage

// ----- design/utf8d_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transfer.
interface utf8d_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/utf8_to_utf16_decoder_top.sv -----
// A byte stages in the input register, its result in the result register. While the output
// takes results, one byte per cycle; a byte that decodes to nothing takes no output slot.
// The input register advances whenever its byte needs no result or the result register frees.
// Reset clears the pipeline valids and returns the decoder to the start of a string.
// Top level of the UTF-8 to UTF-16 decoder.
module utf8_to_utf16_decoder_top
	import utf8d_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	utf8d_stream_if.sink   utf8_bytes,
	utf8d_stream_if.source utf16_units
);

	logic        valid_s1;
	in_item_t    item_s1;
	dec_result_t result;
	logic        out_can_load;
	logic        advance;

	// The staged byte moves on when it yields nothing or the result register can take it.
	assign advance          = valid_s1 && (!result.emit || out_can_load);
	assign utf8_bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (utf8_bytes.ready) begin
			valid_s1 <= utf8_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (utf8_bytes.ready && utf8_bytes.valid) begin
			item_s1 <= utf8_bytes.payload;
		end
	end

	utf8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.consume (advance),
		.item    (item_s1),
		.result  (result)
	);

	utf8d_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && result.emit),
		.item        (result.item),
		.can_load    (out_can_load),
		.utf16_units (utf16_units)
	);

endmodule

// ----- design/utf8d_decode.sv -----
// Decoder state and the per-byte decode logic.
module utf8d_decode
	import utf8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        consume,
	input  in_item_t    item,
	output dec_result_t result
);

	logic [1:0]  rem_q;
	logic [15:0] partial_q;
	logic        start_q;
	logic        mark_q;

	logic [1:0]  rem_d;
	logic [15:0] partial_d;
	logic        start_d;
	logic        mark_d;
	logic        have;
	logic [15:0] code;
	logic [7:0]  b;

	assign b = item.data_byte;

	always_comb begin
		rem_d     = rem_q;
		partial_d = partial_q;
		mark_d    = mark_q;
		start_d   = 1'b0;
		have      = 1'b0;
		code      = 16'h0000;
		case (rem_q)
			RemNone: begin
				if (!b[7]) begin
					code = {8'h00, b};
					have = 1'b1;
				end else if (b[7:5] == 3'b110) begin
					partial_d = {5'b00000, b[4:0], 6'b000000};
					rem_d     = RemOne;
					mark_d    = 1'b0;
				end else if (b[7:5] == 3'b111) begin
					partial_d = {b[3:0], 12'h000};
					rem_d     = RemTwo;
					mark_d    = start_q && (b == BomByte0);
				end
				// A stray continuation byte leaves the state alone.
			end
			RemTwo: begin
				partial_d = partial_q | {4'h0, b[5:0], 6'b000000};
				mark_d    = mark_q && (b == BomByte1);
				rem_d     = RemOne;
			end
			default: begin
				code      = partial_q | {10'b0000000000, b[5:0]};
				have      = !(mark_q && (b == BomByte2));
				rem_d     = RemNone;
				partial_d = 16'h0000;
				mark_d    = 1'b0;
			end
		endcase

		// The last byte of a string always reports and drops anything unfinished.
		if (item.last_byte) begin
			rem_d     = RemNone;
			partial_d = 16'h0000;
			start_d   = 1'b1;
			mark_d    = 1'b0;
		end

		result.emit               = have || item.last_byte;
		result.item.code_unit     = have ? code : 16'h0000;
		result.item.no_character  = !have;
		result.item.end_of_string = item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= RemNone;
			partial_q <= 16'h0000;
			start_q   <= 1'b1;
			mark_q    <= 1'b0;
		end else if (consume) begin
			rem_q     <= rem_d;
			partial_q <= partial_d;
			start_q   <= start_d;
			mark_q    <= mark_d;
		end
	end

endmodule

// ----- design/utf8d_out_reg.sv -----
// Result register that drives the output channel.
module utf8d_out_reg
	import utf8d_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  out_item_t              item,
	output logic                   can_load,
	utf8d_stream_if.source         utf16_units
);

	logic      valid_q;
	out_item_t item_q;

	assign can_load            = !valid_q || utf16_units.ready;
	assign utf16_units.valid   = valid_q;
	assign utf16_units.payload = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			item_q <= item;
		end
	end

endmodule

// ----- design/utf8d_checker.sv -----
// Port-level assertions for the decoder top level, attached by bind.
module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_ready,
	input logic        unit_valid,
	input logic        unit_ready,
	input logic [15:0] code_unit,
	input logic        no_character,
	input logic        end_of_string
);

	// An end marker without a character carries a zero code.
	a_nochar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && no_character |-> code_unit == 16'h0000)
		else $error("no_character result with nonzero code_unit");

	// Only the end of a string can lack a character.
	a_nochar_end: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && no_character |-> end_of_string)
		else $error("no_character result without end_of_string");

	// The input side only stalls behind a result that is waiting on the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> unit_valid && !unit_ready)
		else $error("input stalled while output is free");

	// A waiting result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit_ready |=> unit_valid && $stable(code_unit)
			&& $stable(no_character) && $stable(end_of_string))
		else $error("output changed before transfer");

endmodule

bind utf8_to_utf16_decoder_top utf8d_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.byte_ready    (utf8_bytes.ready),
	.unit_valid    (utf16_units.valid),
	.unit_ready    (utf16_units.ready),
	.code_unit     (utf16_units.payload.code_unit),
	.no_character  (utf16_units.payload.no_character),
	.end_of_string (utf16_units.payload.end_of_string)
);
